### design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

### design/cia_pkg.sv
package cia_pkg;

	localparam logic [4:0] OP_ADD    = 5'd0;
	localparam logic [4:0] OP_SUB    = 5'd1;
	localparam logic [4:0] OP_MUL    = 5'd2;
	localparam logic [4:0] OP_DIV    = 5'd3;
	localparam logic [4:0] OP_MOD    = 5'd4;
	localparam logic [4:0] OP_NEG    = 5'd5;
	localparam logic [4:0] OP_ABS    = 5'd6;
	localparam logic [4:0] OP_AND    = 5'd7;
	localparam logic [4:0] OP_OR     = 5'd8;
	localparam logic [4:0] OP_XOR    = 5'd9;
	localparam logic [4:0] OP_NOT    = 5'd10;
	localparam logic [4:0] OP_SHL    = 5'd11;
	localparam logic [4:0] OP_SAR    = 5'd12;
	localparam logic [4:0] OP_EQ     = 5'd13;
	localparam logic [4:0] OP_NE     = 5'd14;
	localparam logic [4:0] OP_GT     = 5'd15;
	localparam logic [4:0] OP_GE     = 5'd16;
	localparam logic [4:0] OP_LT     = 5'd17;
	localparam logic [4:0] OP_LE     = 5'd18;
	localparam logic [4:0] OP_CMP    = 5'd19;
	localparam logic [4:0] OP_BITLEN = 5'd20;
	localparam logic [4:0] OP_EVEN   = 5'd21;
	localparam logic [4:0] OP_ODD    = 5'd22;
	localparam logic [4:0] OP_POS    = 5'd23;
	localparam logic [4:0] OP_NEGT   = 5'd24;
	localparam logic [4:0] OP_ZERO   = 5'd25;
	localparam logic [4:0] OP_NZERO  = 5'd26;
	localparam logic [4:0] OP_SAFE   = 5'd27;
	localparam logic [4:0] OP_UNSAFE = 5'd28;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	localparam logic signed [63:0] SAFE_LIMIT = 64'sd9007199254740991;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BUSY,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

endpackage

### design/cia_ctrl.sv
module cia_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output cia_pkg::cmd_t cmd,
	input  cia_pkg::sts_t sts,
	output cia_pkg::state_t state
);
	import cia_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_BUSY;
				end
			end
			S_BUSY: begin
				if (sts.done) begin
					state_d = S_FINISH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

### design/cia_dp.sv
module cia_dp #(
	parameter int W = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cia_pkg::cmd_t cmd,
	output cia_pkg::sts_t sts,
	input  logic [4:0]    mode,
	input  logic [63:0]   operand_a,
	input  logic [63:0]   operand_b,
	input  logic [5:0]    shift_amount,
	output logic [63:0]   result_value,
	output logic [1:0]    status
);
	import cia_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [4:0]     mode_q;
	logic [W-1:0]   a_q, b_q, mag_q;
	logic [5:0]     sh_q;
	logic [2*W-1:0] acc_q;
	logic [CW-1:0]  cnt_q, bl_q;
	logic [63:0]    res_q;
	logic [1:0]     st_q;

	logic [W-1:0]   in_a, in_b, mag_a, mag_b;
	logic           is_mul, is_div;
	logic [W:0]     hsum, t, nrem;
	logic           ge;
	logic [2*W-1:0] mul_next, div_next;

	assign in_a  = operand_a[W-1:0];
	assign in_b  = operand_b[W-1:0];
	assign mag_a = in_a[W-1] ? (~in_a + 1'b1) : in_a;
	assign mag_b = in_b[W-1] ? (~in_b + 1'b1) : in_b;

	assign is_mul = (mode_q == OP_MUL);
	assign is_div = (mode_q == OP_DIV) || (mode_q == OP_MOD);

	// shift-add multiply, lsb first
	assign hsum     = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, mag_q} : '0);
	assign mul_next = {hsum, acc_q[W-1:1]};

	// restoring divide, remainder high, quotient low
	assign t        = {acc_q[2*W-1:W], acc_q[W-1]};
	assign ge       = (t >= {1'b0, mag_q});
	assign nrem     = ge ? (t - {1'b0, mag_q}) : t;
	assign div_next = {nrem[W-1:0], acc_q[W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			if (mode == OP_MUL || mode == OP_DIV || mode == OP_MOD || mode == OP_BITLEN) begin
				cnt_q <= CW'(W);
			end else begin
				cnt_q <= '0;
			end
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			a_q    <= in_a;
			b_q    <= in_b;
			sh_q   <= shift_amount;
			bl_q   <= CW'(1);
			if (mode == OP_MUL) begin
				acc_q <= {{W{1'b0}}, mag_b};
				mag_q <= mag_a;
			end else begin
				acc_q <= {{W{1'b0}}, mag_a};
				mag_q <= mag_b;
			end
		end else if (cmd.step) begin
			if (is_mul) begin
				acc_q <= mul_next;
			end else if (is_div) begin
				acc_q <= div_next;
			end else if (acc_q[W-1:1] != '0) begin
				acc_q <= acc_q >> 1;
				bl_q  <= bl_q + 1'b1;
			end
		end
	end

	assign sts.done = (cnt_q == '0);

	// result assembly
	logic           sa, sb, neg, a_min, lt, eq, ovf_p;
	logic [W-1:0]   sum, diff, pl, q, rm, r, r_ok;
	logic [1:0]     st;
	logic [63:0]    a64, shl64, sar64;
	logic [2*W-1:0] lim;

	always_comb begin
		sa    = a_q[W-1];
		sb    = b_q[W-1];
		neg   = sa ^ sb;
		a_min = sa && (a_q[W-2:0] == '0);
		lt    = $signed(a_q) < $signed(b_q);
		eq    = (a_q == b_q);
		sum   = a_q + b_q;
		diff  = a_q - b_q;
		lim   = (2*W)'(1) << (W - 1);
		ovf_p = neg ? (acc_q > lim) : (acc_q >= lim);
		pl    = acc_q[W-1:0];
		q     = acc_q[W-1:0];
		rm    = acc_q[2*W-1:W];
		a64   = 64'($signed(a_q));
		shl64 = a64 << sh_q;
		sar64 = $signed(a64) >>> sh_q;
		r     = '0;
		st    = ST_OK;
		unique case (mode_q)
			OP_ADD: begin
				r = sum;
				if (sa == sb && sum[W-1] != sa) st = ST_OVF;
			end
			OP_SUB: begin
				r = diff;
				if (sa != sb && diff[W-1] != sa) st = ST_OVF;
			end
			OP_MUL: begin
				r = neg ? (~pl + 1'b1) : pl;
				if (ovf_p) st = ST_OVF;
			end
			OP_DIV: begin
				r = neg ? (~q + 1'b1) : q;
				if (b_q == '0) st = ST_DIV0;
				else if (!neg && q[W-1]) st = ST_OVF;
			end
			OP_MOD: begin
				r = sa ? (~rm + 1'b1) : rm;
				if (b_q == '0) st = ST_DIV0;
			end
			OP_NEG: begin
				r = ~a_q + 1'b1;
				if (a_min) st = ST_OVF;
			end
			OP_ABS: begin
				r = sa ? (~a_q + 1'b1) : a_q;
				if (a_min) st = ST_OVF;
			end
			OP_AND:    r = a_q & b_q;
			OP_OR:     r = a_q | b_q;
			OP_XOR:    r = a_q ^ b_q;
			OP_NOT:    r = ~a_q;
			OP_SHL:    r = shl64[W-1:0];
			OP_SAR:    r = sar64[W-1:0];
			OP_EQ:     r = W'(eq);
			OP_NE:     r = W'(!eq);
			OP_GT:     r = W'(!lt && !eq);
			OP_GE:     r = W'(!lt);
			OP_LT:     r = W'(lt);
			OP_LE:     r = W'(lt || eq);
			OP_CMP:    r = lt ? '1 : W'(!eq);
			OP_BITLEN: r = W'(bl_q);
			OP_EVEN:   r = W'(!a_q[0]);
			OP_ODD:    r = W'(a_q[0]);
			OP_POS:    r = W'(!sa);
			OP_NEGT:   r = W'(sa);
			OP_ZERO:   r = W'(a_q == '0);
			OP_NZERO:  r = W'(a_q != '0);
			OP_SAFE:   r = W'($signed(a64) <= SAFE_LIMIT && $signed(a64) >= -SAFE_LIMIT);
			OP_UNSAFE: r = W'($signed(a64) > SAFE_LIMIT || $signed(a64) < -SAFE_LIMIT);
			default:   r = '0;
		endcase
		r_ok = (st == ST_OK) ? r : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= 64'($signed(r_ok));
			st_q  <= st;
		end
	end

	assign result_value = res_q;
	assign status       = st_q;

endmodule

### design/checked_int64_alu.sv
// checked signed alu: one opcode, two signed operands and a shift count go in per beat,
// one result value and a status come out per beat. operands are taken from their low
// DATA_WIDTH bits, sign-extended. multiply, divide, modulo and bit length run on a shared
// accumulator one bit per cycle; all other operations skip the iteration. one item is in
// work at a time: a new beat is taken once the previous item has been moved to the output
// register, which holds the result until the sink takes it. overflow gives status 1 and
// divide by zero status 2, both with a zero value
`include "assert_macros.svh"

module checked_int64_alu #(
	parameter int DATA_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  mode,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	input  logic [5:0]  shift_amount,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_value,
	output logic [1:0]  status
);
	import cia_pkg::*;

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	// sequencer: idle, iterate, hand over to output register
	cia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts),
		.state     (state)
	);

	// operand registers, shared shift-add / restoring divide accumulator, result register
	cia_dp #(
		.W (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.shift_amount (shift_amount),
		.result_value (result_value),
		.status       (status)
	);

	// an accepted beat always makes the block busy on the next cycle
	`ASSERT_NEXT(a_busy_after_load, clk, arst_n, in_valid && !in_stall, in_stall)
	// error results never carry a value
	`ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && status != ST_OK, result_value == '0)
	// status code stays within its defined codes
	`ASSERT_NOW(a_status_code, clk, arst_n, out_valid,
		status == ST_OK || status == ST_OVF || status == ST_DIV0)
	// a fresh result only appears straight after the hand-over state
	`ASSERT_NOW(a_result_source, clk, arst_n, $rose(out_valid), $past(state) == S_FINISH)

endmodule
